/* src/crc8fe_pkg.sv */
package crc8fe_pkg;

    // Configuration register indexes.
    localparam logic [7:0] CFG_START_MARKER = 8'd0;
    localparam logic [7:0] CFG_CRC_POLY     = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [7:0] START_MARKER_RESET = 8'h7E;
    localparam logic [7:0] CRC_POLY_RESET     = 8'h07;

    // Which byte of the frame the held item emits next.
    typedef enum logic [2:0] {
        STEP_MARK,
        STEP_ADDR,
        STEP_LEN,
        STEP_DATA,
        STEP_CRC
    } step_t;

    // One CRC-8 step over a whole byte, MSB first, no reflection.
    function automatic logic [7:0] crc8_update(
        input logic [7:0] crc_in,
        input logic [7:0] data_in,
        input logic [7:0] poly
    );
        logic [7:0] r;
        r = crc_in ^ data_in;
        for (int i = 0; i < 8; i++)
        begin
            if (r[7])
            begin
                r = {r[6:0], 1'b0} ^ poly;
            end
            else
            begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

/* src/crc8fe_in_if.sv */
interface crc8fe_in_if
    import crc8fe_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [7:0] dest_address;
    logic [7:0] payload_length;
    logic       opens_frame;

    modport source (
        output valid, payload_byte, dest_address, payload_length, opens_frame,
        input  ready
    );

    modport sink (
        input  valid, payload_byte, dest_address, payload_length, opens_frame,
        output ready
    );
endinterface

/* src/crc8fe_out_if.sv */
interface crc8fe_out_if
    import crc8fe_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       run_end;

    modport source (
        output valid, frame_byte, frame_end, run_end,
        input  ready
    );

    modport sink (
        input  valid, frame_byte, frame_end, run_end,
        output ready
    );
endinterface

/* src/crc8fe_cfg_if.sv */
interface crc8fe_cfg_if
    import crc8fe_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] addr;
    logic [7:0] data;

    modport source (
        output valid, addr, data,
        input  ready
    );

    modport sink (
        input  valid, addr, data,
        output ready
    );
endinterface

/* src/crc8_frame_encoder.sv */
// CRC-8 frame encoder.
// Items arrive on item_in; each accepted item is held in an input register
// and expanded into frame bytes on result_out, one byte per cycle, through a
// registered output stage. An opening item yields the start marker, address,
// length, first payload byte (if any) and the CRC when the frame completes.
// A payload item yields one byte, or two when it completes the frame and the
// CRC follows. A payload item with no open frame is dropped without results.
// The held item is released in the cycle it emits its last byte, so payload
// items that do not complete the frame flow at one per cycle while result_out
// does not stall; the single output register and the byte-per-cycle emitter
// set the rate.
// Registers are written on cfg (index 0: start marker, 1: CRC polynomial);
// cfg is always ready.
// Reset clears the open frame, running CRC and pending items, and restores
// marker 0x7E and polynomial 0x07. On a result_out stall the output register
// holds its byte and the emitter waits; item_in is ready only on drop or idle.
module crc8_frame_encoder
    import crc8fe_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    crc8fe_cfg_if.sink    cfg,
    crc8fe_in_if.sink     item_in,
    crc8fe_out_if.source  result_out
);

    // Configuration registers.
    logic [7:0] marker_reg;
    logic [7:0] poly_reg;

    // Held input item.
    logic       hold_valid_reg;
    step_t      step_reg;
    step_t      step_next;
    logic [7:0] data_reg;
    logic [7:0] addr_reg;
    logic [7:0] len_reg;

    // Frame state.
    logic       in_frame_reg;
    logic       in_frame_next;
    logic [7:0] remaining_reg;
    logic [7:0] remaining_next;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;

    // Output register.
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_end_reg;
    logic       out_run_end_reg;

    logic       out_free;
    logic       drop;
    logic       emit;
    logic       hold_done;
    logic       accept;
    logic [7:0] res_byte;
    logic       res_frame_end;
    logic       res_last;
    logic [7:0] crc_base;
    logic [7:0] crc_upd;

    // Configuration writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= START_MARKER_RESET;
            poly_reg   <= CRC_POLY_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.addr == CFG_START_MARKER)
            begin
                marker_reg <= cfg.data;
            end
            else if (cfg.addr == CFG_CRC_POLY)
            begin
                poly_reg <= cfg.data;
            end
        end
    end

    // Handshake control.
    assign out_free  = !out_valid_reg || result_out.ready;
    assign drop      = hold_valid_reg && (step_reg == STEP_DATA) && !in_frame_reg;
    assign emit      = hold_valid_reg && out_free && !drop;
    assign hold_done = drop || (emit && res_last);
    assign item_in.ready = !hold_valid_reg || hold_done;
    assign accept    = item_in.valid && item_in.ready;

    // The opening marker starts a fresh CRC.
    assign crc_base = (step_reg == STEP_MARK) ? 8'h00 : crc_reg;
    assign crc_upd  = crc8_update(crc_base, res_byte, poly_reg);

    // Next byte of the frame and the state it leaves behind.
    always_comb
    begin
        res_byte       = crc_reg;
        res_frame_end  = 1'b0;
        res_last       = 1'b0;
        step_next      = step_reg;
        crc_next       = crc_reg;
        remaining_next = remaining_reg;
        in_frame_next  = in_frame_reg;
        case (step_reg)
            STEP_MARK:
            begin
                res_byte      = marker_reg;
                crc_next      = crc_upd;
                in_frame_next = 1'b1;
                step_next     = STEP_ADDR;
            end
            STEP_ADDR:
            begin
                res_byte  = addr_reg;
                crc_next  = crc_upd;
                step_next = STEP_LEN;
            end
            STEP_LEN:
            begin
                res_byte       = len_reg;
                crc_next       = crc_upd;
                remaining_next = len_reg;
                step_next      = (len_reg == 8'd0) ? STEP_CRC : STEP_DATA;
            end
            STEP_DATA:
            begin
                res_byte       = data_reg;
                crc_next       = crc_upd;
                remaining_next = remaining_reg - 8'd1;
                if (remaining_next == 8'd0)
                begin
                    step_next = STEP_CRC;
                end
                else
                begin
                    res_last = 1'b1;
                end
            end
            STEP_CRC:
            begin
                res_byte       = crc_reg;
                res_frame_end  = 1'b1;
                res_last       = 1'b1;
                crc_next       = 8'h00;
                remaining_next = 8'd0;
                in_frame_next  = 1'b0;
            end
            default:
            begin
                res_last = 1'b1;
            end
        endcase
    end

    // Held item control and frame state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            step_reg       <= STEP_MARK;
            in_frame_reg   <= 1'b0;
            remaining_reg  <= 8'd0;
            crc_reg        <= 8'h00;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                hold_valid_reg <= 1'b1;
                step_reg       <= item_in.opens_frame ? STEP_MARK : STEP_DATA;
            end
            else if (hold_done)
            begin
                hold_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                step_reg <= step_next;
            end

            if (emit)
            begin
                in_frame_reg  <= in_frame_next;
                remaining_reg <= remaining_next;
                crc_reg       <= crc_next;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= item_in.payload_byte;
            addr_reg <= item_in.dest_address;
            len_reg  <= item_in.payload_length;
        end
        if (emit)
        begin
            out_byte_reg    <= res_byte;
            out_end_reg     <= res_frame_end;
            out_run_end_reg <= res_last;
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.frame_byte = out_byte_reg;
    assign result_out.frame_end  = out_end_reg;
    assign result_out.run_end    = out_run_end_reg;

endmodule
